// ----- rtl/hnm_pkg.sv -----
// Shared types, constants and a helper function of the height-to-normal-map block.
`default_nettype none
package hnm_pkg;

    // Field widths
    localparam int H_BITS        = 16;
    localparam int N_BITS        = 16;
    localparam int NZ_BITS       = 15;
    localparam int FW_BITS       = 11;
    localparam int FH_BITS       = 16;
    localparam int Z_BITS        = 24;
    localparam int CFG_DATA_BITS = 24;
    localparam int SLOPE_BITS    = H_BITS + 3;

    // Arithmetic widths of the normalising unit
    localparam int MAG_BITS  = 24;
    localparam int SUM_BITS  = 2 * MAG_BITS + 2;
    localparam int RAD_BITS  = SUM_BITS + 12;
    localparam int ROOT_BITS = RAD_BITS / 2;
    localparam int QUO_BITS  = 17;
    localparam int NUM_BITS  = MAG_BITS + 22;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam logic [NZ_BITS-1:0] UNIT_VAL = '1;
    localparam logic [Z_BITS-1:0]  Z_ONE    = Z_BITS'(256);

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH    = 2'd0,
        CFG_FRAME_HEIGHT   = 2'd1,
        CFG_INVALID_HEIGHT = 2'd2,
        CFG_Z_TERM         = 2'd3
    } t_cfg_index;

    // Sequencer states
    typedef enum logic [2:0] {
        T_IDLE,
        T_READ,
        T_SLOPE,
        T_CALC,
        T_EMIT,
        T_UPDATE
    } t_top_state;

    // Normalising unit states
    typedef enum logic [2:0] {
        U_IDLE,
        U_SQUARE,
        U_ROOT,
        U_DIVIDE,
        U_DONE
    } t_nu_state;

    // Request to the normalising unit
    typedef struct packed {
        logic                start;
        logic [MAG_BITS-1:0] ax;
        logic [MAG_BITS-1:0] ay;
        logic [MAG_BITS-1:0] az;
    } t_nu_req;

    // Status and result of the normalising unit
    typedef struct packed {
        logic               busy;
        logic               done;
        logic [NZ_BITS-1:0] nx;
        logic [NZ_BITS-1:0] ny;
        logic [NZ_BITS-1:0] nz;
    } t_nu_rsp;

    // Twice the slope: central when both neighbours are valid, else one-sided, else zero.
    function automatic logic signed [SLOPE_BITS-1:0] slope2(
        input logic                     a_ok,
        input logic signed [H_BITS-1:0] a,
        input logic                     b_ok,
        input logic signed [H_BITS-1:0] b,
        input logic signed [H_BITS-1:0] c
    );
        logic signed [SLOPE_BITS-1:0] ea;
        logic signed [SLOPE_BITS-1:0] eb;
        logic signed [SLOPE_BITS-1:0] ec;
        ea = SLOPE_BITS'(a);
        eb = SLOPE_BITS'(b);
        ec = SLOPE_BITS'(c);
        if (a_ok && b_ok) begin
            slope2 = eb - ea;
        end else if (b_ok) begin
            slope2 = (eb - ec) <<< 1;
        end else if (a_ok) begin
            slope2 = (ec - ea) <<< 1;
        end else begin
            slope2 = '0;
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/hnm_line_store.sv -----
// Line store memory holding two rows of height samples, registered read.
`default_nettype none
module hnm_line_store #(
    parameter int ADDR_BITS = 11,
    parameter int DATA_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [ADDR_BITS-1:0] i_waddr,
    input  wire logic [DATA_BITS-1:0] i_wdata,
    input  wire logic [ADDR_BITS-1:0] i_raddr,
    output logic      [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [2**ADDR_BITS];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/hnm_normal_unit.sv -----
// Normalising unit: sum of squares, bit-serial square root and three serial divisions.
`default_nettype none
module hnm_normal_unit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire hnm_pkg::t_nu_req i_req,
    output hnm_pkg::t_nu_rsp      o_rsp
);

    localparam int MB = hnm_pkg::MAG_BITS;
    localparam int SB = hnm_pkg::SUM_BITS;
    localparam int RB = hnm_pkg::RAD_BITS;
    localparam int TB = hnm_pkg::ROOT_BITS;
    localparam int QB = hnm_pkg::QUO_BITS;
    localparam int NB = hnm_pkg::NUM_BITS;
    localparam int ZB = hnm_pkg::NZ_BITS;

    hnm_pkg::t_nu_state r_state;
    hnm_pkg::t_nu_state n_state;
    logic [4:0]         r_cnt;
    logic [1:0]         r_comp;

    logic [MB-1:0]   r_ax;
    logic [MB-1:0]   r_ay;
    logic [MB-1:0]   r_az;
    logic [2*MB-1:0] r_prod;
    logic [SB-1:0]   r_acc;
    logic [RB-1:0]   r_rad;
    logic [TB-1:0]   r_root;
    logic [TB+1:0]   r_rem;
    logic [QB-1:0]   r_dnum;
    logic [TB-1:0]   r_drem;
    logic [QB-1:0]   r_quo;
    logic [ZB-1:0]   r_nx;
    logic [ZB-1:0]   r_ny;
    logic [ZB-1:0]   r_nz;

    logic [MB-1:0] w_sq_op;
    logic [TB+3:0] w_rt_rem;
    logic [TB+3:0] w_rt_trial;
    logic          w_rt_ge;
    logic [MB-1:0] w_div_a;
    logic [NB-1:0] w_num;
    logic [TB:0]   w_dv_t;
    logic          w_dv_ge;
    logic [QB-1:0] w_quo;
    logic [ZB-1:0] w_quo_cap;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            hnm_pkg::U_IDLE: begin
                if (i_req.start) n_state = hnm_pkg::U_SQUARE;
            end
            hnm_pkg::U_SQUARE: begin
                if (r_cnt == 5'd3) n_state = hnm_pkg::U_ROOT;
            end
            hnm_pkg::U_ROOT: begin
                if (r_cnt == 5'(TB - 1)) n_state = hnm_pkg::U_DIVIDE;
            end
            hnm_pkg::U_DIVIDE: begin
                if (r_cnt == 5'(QB) && r_comp == 2'd2) n_state = hnm_pkg::U_DONE;
            end
            hnm_pkg::U_DONE: begin
                n_state = hnm_pkg::U_IDLE;
            end
            default: begin
                n_state = hnm_pkg::U_IDLE;
            end
        endcase
    end

    // Status and results.
    always_comb begin
        o_rsp.busy = (r_state != hnm_pkg::U_IDLE);
        o_rsp.done = (r_state == hnm_pkg::U_DONE);
        o_rsp.nx   = r_nx;
        o_rsp.ny   = r_ny;
        o_rsp.nz   = r_nz;
    end

    // Operand of the shared multiplier, and one step of the square root.
    always_comb begin
        case (r_cnt)
            5'd0:    w_sq_op = r_ax;
            5'd1:    w_sq_op = r_ay;
            default: w_sq_op = r_az;
        endcase
        w_rt_rem   = {r_rem, r_rad[RB-1 -: 2]};
        w_rt_trial = {2'b00, r_root, 2'b01};
        w_rt_ge    = (w_rt_rem >= w_rt_trial);
    end

    // Numerator a * 32767 * 64 + length / 2 for the component being divided.
    always_comb begin
        case (r_comp)
            2'd0:    w_div_a = r_ax;
            2'd1:    w_div_a = r_ay;
            default: w_div_a = r_az;
        endcase
        w_num = (NB'(w_div_a) << 21) - (NB'(w_div_a) << 6) + NB'(r_root >> 1);
        w_dv_t    = {r_drem, r_dnum[QB-1]};
        w_dv_ge   = (w_dv_t >= {1'b0, r_root});
        w_quo     = {r_quo[QB-2:0], w_dv_ge};
        w_quo_cap = (w_quo > QB'(hnm_pkg::UNIT_VAL)) ? hnm_pkg::UNIT_VAL : w_quo[ZB-1:0];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hnm_pkg::U_IDLE;
            r_cnt   <= '0;
            r_comp  <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                hnm_pkg::U_IDLE: begin
                    r_cnt <= '0;
                end
                hnm_pkg::U_SQUARE, hnm_pkg::U_ROOT: begin
                    if (n_state != r_state) begin
                        r_cnt  <= '0;
                        r_comp <= '0;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                hnm_pkg::U_DIVIDE: begin
                    if (r_cnt == 5'(QB)) begin
                        r_cnt  <= '0;
                        r_comp <= r_comp + 2'd1;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                default: begin
                    r_cnt <= '0;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            hnm_pkg::U_IDLE: begin
                r_ax  <= i_req.ax;
                r_ay  <= i_req.ay;
                r_az  <= i_req.az;
                r_acc <= '0;
            end
            hnm_pkg::U_SQUARE: begin
                r_prod <= w_sq_op * w_sq_op;
                if (r_cnt == 5'd1 || r_cnt == 5'd2) begin
                    r_acc <= r_acc + SB'(r_prod);
                end
                if (r_cnt == 5'd3) begin
                    r_rad  <= {r_acc + SB'(r_prod), 12'b0};
                    r_root <= '0;
                    r_rem  <= '0;
                end
            end
            hnm_pkg::U_ROOT: begin
                r_rad <= r_rad << 2;
                if (w_rt_ge) begin
                    r_rem  <= (TB+2)'(w_rt_rem - w_rt_trial);
                    r_root <= {r_root[TB-2:0], 1'b1};
                end else begin
                    r_rem  <= (TB+2)'(w_rt_rem);
                    r_root <= {r_root[TB-2:0], 1'b0};
                end
            end
            hnm_pkg::U_DIVIDE: begin
                if (r_cnt == 5'd0) begin
                    // Quotient stays below 2^QB, so the upper part is already below the length.
                    r_drem <= TB'(w_num >> QB);
                    r_dnum <= w_num[QB-1:0];
                    r_quo  <= '0;
                end else begin
                    r_drem <= w_dv_ge ? TB'(w_dv_t - {1'b0, r_root}) : TB'(w_dv_t);
                    r_dnum <= r_dnum << 1;
                    r_quo  <= w_quo;
                    if (r_cnt == 5'(QB)) begin
                        case (r_comp)
                            2'd0:    r_nx <= w_quo_cap;
                            2'd1:    r_ny <= w_quo_cap;
                            default: r_nz <= w_quo_cap;
                        endcase
                    end
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

`ifndef SYNTH
    // The length is never zero because z is at least one.
    a_root_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hnm_pkg::U_DIVIDE) |-> (r_root != '0))
        else $error("normal length is zero during division");

    // The partial remainder stays below the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hnm_pkg::U_DIVIDE && r_cnt != 5'd0) |-> (r_drem < r_root))
        else $error("division remainder out of range");

    // Completion is a single-cycle pulse.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.done |=> !o_rsp.done)
        else $error("done held for more than one cycle");
`endif

endmodule
`default_nettype wire

// ----- rtl/height_to_normal_map.sv -----
// Top level: sequencer around the line store and the normalising unit.
// An item with a normal goes through accept, line-store reads, slope, the normalising
// unit (squaring, a 31-bit bit-serial root, three serial divisions), emit and update.
// An invalid centre pixel skips the normalising unit; an item with no result goes
// from accept to update, or stays idle when draining. Samples are taken only in idle.
// Results lag the samples by one row. Synchronous active-low reset clears the
// control state and loads the register defaults; the line store is not cleared.
`default_nettype none
module height_to_normal_map #(
    parameter int MAX_WIDTH = hnm_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic signed [hnm_pkg::H_BITS-1:0]    i_sample,
    input  wire logic                                 i_drain,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic signed [hnm_pkg::N_BITS-1:0]         o_normal_x,
    output logic signed [hnm_pkg::N_BITS-1:0]         o_normal_y,
    output logic        [hnm_pkg::NZ_BITS-1:0]        o_normal_z,
    output logic                                      o_frame_last,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [1:0]                           i_cfg_index,
    input  wire logic [hnm_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;
    localparam int HB = hnm_pkg::H_BITS;
    localparam int FH = hnm_pkg::FH_BITS;
    localparam int NB = hnm_pkg::N_BITS;
    localparam int ZB = hnm_pkg::NZ_BITS;
    localparam int MB = hnm_pkg::MAG_BITS;
    localparam int SL = hnm_pkg::SLOPE_BITS;

    // Configuration registers
    logic [hnm_pkg::FW_BITS-1:0] r_frame_width;
    logic [FH-1:0]               r_frame_height;
    logic signed [HB-1:0]        r_invalid_height;
    logic [hnm_pkg::Z_BITS-1:0]  r_z_term;

    // Sequencer and frame position
    hnm_pkg::t_top_state r_state;
    hnm_pkg::t_top_state n_state;
    logic [2:0]          r_rd_cnt;
    logic                r_bank;
    logic [CW-1:0]       r_in_col;
    logic [FH-1:0]       r_in_row;
    logic [CW-1:0]       r_out_col;
    logic [FH-1:0]       r_out_row;
    logic                r_out_pend;
    logic                r_out_tail;
    logic                r_emit;
    logic                r_drain;
    logic signed [HB-1:0] r_sample;

    // Neighbourhood read from the line store
    logic signed [HB-1:0] r_hc;
    logic signed [HB-1:0] r_hl;
    logic signed [HB-1:0] r_hr;
    logic signed [HB-1:0] r_hu;

    // Result staging and output register
    logic                 r_x_neg;
    logic                 r_y_neg;
    logic                 r_res_last;
    logic signed [NB-1:0] r_res_x;
    logic signed [NB-1:0] r_res_y;
    logic [ZB-1:0]        r_res_z;
    logic                 r_out_valid;
    logic signed [NB-1:0] r_o_x;
    logic signed [NB-1:0] r_o_y;
    logic [ZB-1:0]        r_o_z;
    logic                 r_o_last;

    logic [WW-1:0]   w_eff_w;
    logic [FH-1:0]   w_eff_h;
    logic            w_in_acc;
    logic            w_emit;
    logic            w_load_out;
    logic            w_we;
    logic [CW:0]     w_raddr;
    logic [HB-1:0]   w_rdata;
    logic            w_c_bad;
    logic            w_l_ok;
    logic            w_r_ok;
    logic            w_u_ok;
    logic            w_d_ok;
    logic signed [SL-1:0] w_dx2;
    logic signed [SL-1:0] w_dy2;
    logic [SL-1:0]   w_adx;
    logic [SL-1:0]   w_ady;
    logic            w_col_end;
    logic            w_in_end;
    logic            w_tail_next;
    hnm_pkg::t_nu_req w_req;
    hnm_pkg::t_nu_rsp w_rsp;

    // Effective frame size after clamping.
    always_comb begin
        if (r_frame_width == '0) begin
            w_eff_w = WW'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w_eff_w = WW'(MAX_WIDTH);
        end else begin
            w_eff_w = WW'(r_frame_width);
        end
        w_eff_h     = (r_frame_height == '0) ? FH'(1) : r_frame_height;
        w_col_end   = ({1'b0, r_out_col} + WW'(1)) >= w_eff_w;
        w_in_end    = ({1'b0, r_in_col} + WW'(1)) >= w_eff_w;
        w_tail_next = ({1'b0, r_in_row} + (FH+1)'(1)) >= {1'b0, w_eff_h};
    end

    // Handshake and sequencer outputs.
    always_comb begin
        o_in_ready  = (r_state == hnm_pkg::T_IDLE);
        o_cfg_ready = 1'b1;
        w_in_acc    = i_in_valid && o_in_ready;
        w_emit      = i_drain ? (r_out_pend && r_out_tail) : r_out_pend;
        w_load_out  = (r_state == hnm_pkg::T_EMIT) && (!r_out_valid || i_out_ready);
        w_we        = (r_state == hnm_pkg::T_UPDATE) && !r_drain;
        o_out_valid  = r_out_valid;
        o_normal_x   = r_o_x;
        o_normal_y   = r_o_y;
        o_normal_z   = r_o_z;
        o_frame_last = r_o_last;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            hnm_pkg::T_IDLE: begin
                if (w_in_acc) begin
                    if (w_emit) n_state = hnm_pkg::T_READ;
                    else if (!i_drain) n_state = hnm_pkg::T_UPDATE;
                end
            end
            hnm_pkg::T_READ: begin
                if (r_rd_cnt == 3'd4) n_state = hnm_pkg::T_SLOPE;
            end
            hnm_pkg::T_SLOPE: begin
                n_state = w_c_bad ? hnm_pkg::T_EMIT : hnm_pkg::T_CALC;
            end
            hnm_pkg::T_CALC: begin
                if (w_rsp.done) n_state = hnm_pkg::T_EMIT;
            end
            hnm_pkg::T_EMIT: begin
                if (w_load_out) n_state = hnm_pkg::T_UPDATE;
            end
            hnm_pkg::T_UPDATE: begin
                n_state = hnm_pkg::T_IDLE;
            end
            default: begin
                n_state = hnm_pkg::T_IDLE;
            end
        endcase
    end

    // Read address: centre, left, right from the middle row, then the row above.
    always_comb begin
        case (r_rd_cnt)
            3'd0:    w_raddr = {~r_bank, r_out_col};
            3'd1:    w_raddr = {~r_bank, CW'(r_out_col - 1'b1)};
            3'd2:    w_raddr = {~r_bank, CW'(r_out_col + 1'b1)};
            default: w_raddr = {r_bank, r_out_col};
        endcase
    end

    hnm_line_store #(
        .ADDR_BITS(CW + 1),
        .DATA_BITS(HB)
    ) u_line_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr({r_bank, r_in_col}),
        .i_wdata(r_sample),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // Neighbour validity and slopes; neighbours outside the frame count as invalid.
    always_comb begin
        w_c_bad = (r_hc == r_invalid_height);
        w_l_ok  = (r_out_col != '0) && (r_hl != r_invalid_height);
        w_r_ok  = !w_col_end && (r_hr != r_invalid_height);
        w_u_ok  = (r_out_row != '0) && (r_hu != r_invalid_height);
        w_d_ok  = !r_drain && !r_out_tail && (r_sample != r_invalid_height);
        w_dx2   = hnm_pkg::slope2(w_l_ok, r_hl, w_r_ok, r_hr, r_hc);
        w_dy2   = hnm_pkg::slope2(w_u_ok, r_hu, w_d_ok, r_sample, r_hc);
        w_adx   = (w_dx2 < 0) ? SL'(-w_dx2) : SL'(w_dx2);
        w_ady   = (w_dy2 < 0) ? SL'(-w_dy2) : SL'(w_dy2);
        w_req.start = (r_state == hnm_pkg::T_SLOPE) && !w_c_bad;
        w_req.ax    = {w_adx[MB-8:0], 7'b0};
        w_req.ay    = {w_ady[MB-8:0], 7'b0};
        w_req.az    = (r_z_term == '0) ? hnm_pkg::Z_ONE : r_z_term;
    end

    hnm_normal_unit u_normal_unit (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width    <= hnm_pkg::FW_BITS'(1024);
            r_frame_height   <= FH'(1024);
            r_invalid_height <= '0;
            r_z_term         <= hnm_pkg::Z_ONE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (hnm_pkg::t_cfg_index'(i_cfg_index))
                hnm_pkg::CFG_FRAME_WIDTH:    r_frame_width    <= i_cfg_data[hnm_pkg::FW_BITS-1:0];
                hnm_pkg::CFG_FRAME_HEIGHT:   r_frame_height   <= i_cfg_data[FH-1:0];
                hnm_pkg::CFG_INVALID_HEIGHT: r_invalid_height <= i_cfg_data[HB-1:0];
                hnm_pkg::CFG_Z_TERM:         r_z_term         <= i_cfg_data;
                default:                     r_z_term         <= r_z_term;
            endcase
        end
    end

    // Sequencer, frame position and output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hnm_pkg::T_IDLE;
            r_rd_cnt    <= '0;
            r_bank      <= 1'b0;
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_out_pend  <= 1'b0;
            r_out_tail  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == hnm_pkg::T_READ) begin
                r_rd_cnt <= r_rd_cnt + 3'd1;
            end else begin
                r_rd_cnt <= '0;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == hnm_pkg::T_UPDATE) begin
                // Step past the normal just sent.
                if (r_emit) begin
                    if (w_col_end) begin
                        r_out_col  <= '0;
                        r_out_pend <= 1'b0;
                    end else begin
                        r_out_col <= r_out_col + 1'b1;
                    end
                end
                // Store the sample; a finished row becomes the pending row.
                if (!r_drain) begin
                    if (w_in_end) begin
                        r_in_col   <= '0;
                        r_out_pend <= 1'b1;
                        r_out_row  <= r_in_row;
                        r_out_col  <= '0;
                        r_out_tail <= w_tail_next;
                        r_bank     <= ~r_bank;
                        r_in_row   <= w_tail_next ? '0 : r_in_row + 1'b1;
                    end else begin
                        r_in_col <= r_in_col + 1'b1;
                    end
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sample <= i_sample;
            r_drain  <= i_drain;
            r_emit   <= w_emit;
        end
        if (r_state == hnm_pkg::T_READ) begin
            case (r_rd_cnt)
                3'd1:    r_hc <= w_rdata;
                3'd2:    r_hl <= w_rdata;
                3'd3:    r_hr <= w_rdata;
                3'd4:    r_hu <= w_rdata;
                default: r_hc <= r_hc;
            endcase
        end
        if (r_state == hnm_pkg::T_SLOPE) begin
            r_x_neg    <= (w_dx2 > 0);
            r_y_neg    <= (w_dy2 > 0);
            r_res_last <= r_out_tail && w_col_end;
            if (w_c_bad) begin
                r_res_x <= '0;
                r_res_y <= '0;
                r_res_z <= hnm_pkg::UNIT_VAL;
            end
        end
        if (r_state == hnm_pkg::T_CALC && w_rsp.done) begin
            r_res_x <= r_x_neg ? -NB'(w_rsp.nx) : NB'(w_rsp.nx);
            r_res_y <= r_y_neg ? -NB'(w_rsp.ny) : NB'(w_rsp.ny);
            r_res_z <= w_rsp.nz;
        end
        if (w_load_out) begin
            r_o_x    <= r_res_x;
            r_o_y    <= r_res_y;
            r_o_z    <= r_res_z;
            r_o_last <= r_res_last;
        end
    end

`ifndef SYNTH
    // The unit is started only when it has finished the previous normal.
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> !w_rsp.busy)
        else $error("normalising unit started while busy");

    // A finished normal arrives only while the sequencer waits for it.
    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == hnm_pkg::T_CALC))
        else $error("normal finished outside the calculation state");

    // A new output transaction is offered only after the emit state.
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == hnm_pkg::T_EMIT))
        else $error("output loaded outside the emit state");
`endif

endmodule
`default_nettype wire
